>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted list table engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SLTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle
`define SLTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/slte_pkg.sv
// ---------------------------------------------------------------------------
// slte_pkg
// Types and constants shared by the controller and datapath of the sorted
// list table engine.
// ---------------------------------------------------------------------------
package slte_pkg;

    localparam int KEY_W   = 31;
    localparam int PAY_W   = 64;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 3;
    localparam int TDATA_W = 96;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_LIST   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SEEK,
        DP_WALK,
        DP_FREE_RD,
        DP_INS_A,
        DP_INS_B,
        DP_DEL_A,
        DP_DEL_B,
        DP_MOD,
        DP_RESP,
        DP_LIST_HEAD,
        DP_LIST_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [STAT_W-1:0]   status;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             walk_done;
        logic             walk_hit;
        logic             free_empty;
        logic             head_empty;
        logic             out_free;
        logic             list_fin;
    } dp_stat_t;

endpackage

>>> rtl/core/slte_dp.sv
// ---------------------------------------------------------------------------
// slte_dp
// Datapath: slot table memories, chain pointers, walk registers and the
// result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slte_dp import slte_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [REQ_W-1:0]     s_tuser,   // req_type
    input  logic [TDATA_W-1:0]   s_tdata,   // record_key, record_payload
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // out_key, out_payload
    output logic [STAT_W-1:0]    m_tuser,   // status
    output logic                 m_tlast
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Slot table
    logic [SW-1:0]    link_mem [CAPACITY];
    logic [KEY_W-1:0] key_mem  [CAPACITY];
    logic [PAY_W-1:0] pay_mem  [CAPACITY];
    logic [CAPACITY-1:0] link_vld_reg;

    // Request and walk registers
    logic [REQ_W-1:0] req_type_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [PAY_W-1:0] req_pay_reg;
    logic [SW-1:0]    head_reg;
    logic [SW-1:0]    free_reg;
    logic [SW-1:0]    cur_reg;
    logic [SW-1:0]    prev_reg;
    logic [SW-1:0]    succ_reg;
    logic [SW-1:0]    new_reg;
    logic [CW-1:0]    steps_reg;

    // Read data
    logic [SW-1:0]    link_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [PAY_W-1:0] pay_rd_reg;

    // Result register
    logic              m_tvalid_reg;
    logic [STAT_W-1:0] out_st_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [PAY_W-1:0]  out_pay_reg;
    logic              out_last_reg;

    logic             rd_en;
    logic [SW-1:0]    rd_addr;
    logic             lw_en;
    logic [SW-1:0]    lw_addr;
    logic [SW-1:0]    lw_data;
    logic             pw_en;
    logic [SW-1:0]    pw_addr;
    logic             kw_en;
    logic             walk_done;
    logic             walk_hit;
    logic             steps_max;
    logic             list_fin;
    logic             out_free;
    logic             out_load;

    // Link of a slot that was never written: the next slot, the last one ends
    function automatic logic [SW-1:0] reset_link(input logic [SW-1:0] a);
        reset_link = (a == SW'(CAPACITY - 1)) ? '0 : a + SW'(1);
    endfunction

    // Walk and list status
    assign steps_max = (steps_reg == CW'(CAPACITY));
    assign walk_done = (cur_reg == '0) || steps_max || !(req_key_reg > key_rd_reg);
    assign walk_hit  = (cur_reg != '0) && !steps_max && (key_rd_reg == req_key_reg);
    assign list_fin  = (link_rd_reg == '0) || (steps_reg == CW'(CAPACITY - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (cmd.op == DP_RESP) || (cmd.op == DP_LIST_EMIT);

    assign stat.req_type   = req_type_reg;
    assign stat.walk_done  = walk_done;
    assign stat.walk_hit   = walk_hit;
    assign stat.free_empty = (free_reg == '0);
    assign stat.head_empty = (head_reg == '0);
    assign stat.out_free   = out_free;
    assign stat.list_fin   = list_fin;

    // Select read address and write ports for the current operation
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        lw_en   = 1'b0;
        lw_addr = cur_reg;
        lw_data = cur_reg;
        pw_en   = 1'b0;
        pw_addr = cur_reg;
        kw_en   = 1'b0;
        unique case (cmd.op)
            DP_SEEK, DP_LIST_HEAD: begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
            end
            DP_WALK: begin
                rd_en   = !walk_done;
                rd_addr = link_rd_reg;
            end
            DP_LIST_EMIT: begin
                rd_en   = !list_fin;
                rd_addr = link_rd_reg;
            end
            DP_FREE_RD: begin
                rd_en   = 1'b1;
                rd_addr = free_reg;
            end
            DP_INS_A: begin
                lw_en   = 1'b1;
                lw_addr = free_reg;
                lw_data = cur_reg;
                pw_en   = 1'b1;
                pw_addr = free_reg;
                kw_en   = 1'b1;
            end
            DP_INS_B: begin
                lw_en   = (prev_reg != '0);
                lw_addr = prev_reg;
                lw_data = new_reg;
            end
            DP_DEL_A: begin
                lw_en   = 1'b1;
                lw_addr = cur_reg;
                lw_data = free_reg;
            end
            DP_DEL_B: begin
                lw_en   = (prev_reg != '0);
                lw_addr = prev_reg;
                lw_data = succ_reg;
            end
            DP_MOD: begin
                pw_en   = 1'b1;
                pw_addr = cur_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Write and read the slot table
    always_ff @(posedge aclk) begin
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
        if (kw_en) begin
            key_mem[pw_addr] <= req_key_reg;
        end
        if (pw_en) begin
            pay_mem[pw_addr] <= req_pay_reg;
        end
        if (rd_en) begin
            link_rd_reg <= link_vld_reg[rd_addr] ? link_mem[rd_addr] : reset_link(rd_addr);
            key_rd_reg  <= key_mem[rd_addr];
            pay_rd_reg  <= pay_mem[rd_addr];
        end
    end

    // Mark written links; unwritten ones read as the initial free chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (lw_en) begin
            link_vld_reg[lw_addr] <= 1'b1;
        end
    end

    // Chain heads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            free_reg <= SW'(1);
        end else begin
            case (cmd.op)
                DP_INS_A: free_reg <= link_rd_reg;
                DP_INS_B: begin
                    if (prev_reg == '0) begin
                        head_reg <= new_reg;
                    end
                end
                DP_DEL_A: free_reg <= cur_reg;
                DP_DEL_B: begin
                    if (prev_reg == '0) begin
                        head_reg <= succ_reg;
                    end
                end
                default: begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    // Request capture and walk pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else begin
            case (cmd.op)
                DP_LOAD: begin
                    req_type_reg <= s_tuser;
                    req_key_reg  <= s_tdata[KEY_W-1:0];
                    req_pay_reg  <= s_tdata[KEY_W +: PAY_W];
                end
                DP_SEEK, DP_LIST_HEAD: begin
                    cur_reg   <= head_reg;
                    prev_reg  <= '0;
                    steps_reg <= '0;
                end
                DP_WALK: begin
                    if (walk_done) begin
                        if (steps_max) begin
                            cur_reg <= '0;
                        end
                        succ_reg <= link_rd_reg;
                    end else begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= link_rd_reg;
                        steps_reg <= steps_reg + CW'(1);
                    end
                end
                DP_LIST_EMIT: begin
                    cur_reg   <= link_rd_reg;
                    steps_reg <= steps_reg + CW'(1);
                end
                DP_INS_A: new_reg <= free_reg;
                default: begin
                    new_reg <= new_reg;
                end
            endcase
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LIST_EMIT) begin
            out_st_reg   <= ST_OK;
            out_key_reg  <= key_rd_reg;
            out_pay_reg  <= pay_rd_reg;
            out_last_reg <= list_fin;
        end else if (cmd.op == DP_RESP) begin
            out_st_reg   <= cmd.status;
            out_key_reg  <= req_key_reg;
            out_pay_reg  <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(TDATA_W - KEY_W - PAY_W){1'b0}}, out_pay_reg, out_key_reg};

    `SLTE_ASSERT(a_load_free, aclk, aresetn, !out_load || out_free, "result over pending beat")
    `SLTE_ASSERT(a_steps_bound, aclk, aresetn, steps_reg <= CW'(CAPACITY), "walk overran")
    `SLTE_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.op == DP_LIST_EMIT, m_tvalid, "beat lost")

endmodule

>>> rtl/core/slte_ctrl.sv
// ---------------------------------------------------------------------------
// slte_ctrl
// Controller: sequences walk, update and result steps for each request.
// ---------------------------------------------------------------------------
module slte_ctrl import slte_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_FREE   = 8'b0000_1000,
        S_EXEC_A = 8'b0001_0000,
        S_EXEC_B = 8'b0010_0000,
        S_RESP   = 8'b0100_0000,
        S_LIST   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] st_reg, st_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and datapath command
    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = DP_NONE;
        cmd.status = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.req_type == REQ_LIST) begin
                    if (stat.head_empty) begin
                        st_next    = ST_EMPTY;
                        state_next = S_RESP;
                    end else begin
                        cmd.op     = DP_LIST_HEAD;
                        state_next = S_LIST;
                    end
                end else begin
                    cmd.op     = DP_SEEK;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                cmd.op = DP_WALK;
                if (stat.walk_done) begin
                    st_next = ST_OK;
                    case (stat.req_type)
                        REQ_INSERT: begin
                            if (stat.walk_hit) begin
                                st_next    = ST_DUP;
                                state_next = S_RESP;
                            end else if (stat.free_empty) begin
                                st_next    = ST_FULL;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_FREE;
                            end
                        end
                        default: begin
                            if (stat.walk_hit) begin
                                state_next = S_EXEC_A;
                            end else begin
                                st_next    = ST_NOTFOUND;
                                state_next = S_RESP;
                            end
                        end
                    endcase
                end
            end
            S_FREE: begin
                cmd.op     = DP_FREE_RD;
                state_next = S_EXEC_A;
            end
            S_EXEC_A: begin
                case (stat.req_type)
                    REQ_INSERT: begin
                        cmd.op     = DP_INS_A;
                        state_next = S_EXEC_B;
                    end
                    REQ_MODIFY: begin
                        cmd.op     = DP_MOD;
                        state_next = S_RESP;
                    end
                    default: begin
                        cmd.op     = DP_DEL_A;
                        state_next = S_EXEC_B;
                    end
                endcase
            end
            S_EXEC_B: begin
                cmd.op     = (stat.req_type == REQ_INSERT) ? DP_INS_B : DP_DEL_B;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.op     = DP_RESP;
                    state_next = S_IDLE;
                end
            end
            S_LIST: begin
                if (stat.out_free) begin
                    cmd.op = DP_LIST_EMIT;
                    if (stat.list_fin) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

>>> rtl/core/sorted_list_table_engine.sv
// ---------------------------------------------------------------------------
// sorted_list_table_engine
// Sorted record table with a free chain: insert, modify, delete and list.
// ---------------------------------------------------------------------------
// Records (31-bit key, 64-bit payload) live in a table of CAPACITY slots and
// hold up to CAPACITY-1 records, chained in ascending key order; slot 0 is
// never used. The table has one read port, so a walk passes one record per
// cycle. Insert, modify and delete load the request, walk past each record
// before the key's position, run any update steps and then a result step.
// List loads the request, reads the head and then emits one beat per record
// in key order while m_tready stays high. The next request is taken as soon
// as the last result sits in the output register. The free chain starts in
// its reset order at once; there is no clearing pass after reset.
// ---------------------------------------------------------------------------
module sorted_list_table_engine import slte_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [30:0] record_key, [94:31] record_payload
    input  logic [REQ_W-1:0]    s_tuser,   // [1:0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [30:0] out_key, [94:31] out_payload
    output logic [STAT_W-1:0]   m_tuser,   // [2:0] status
    output logic                m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each request
    slte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the table and the result register
    slte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
